/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MFLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define MFLE_NEVER(lbl, expr, msg) \
  `MFLE_ASSERT(lbl, !(expr), msg)

`endif

/* hdl/mfle_pkg.sv */
// Shared types, codes and matcher functions of the mail From-line extractor.
`default_nettype none

package mfle_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_USER   = 3'd2;
  localparam logic [2:0] PH_SEARCH = 3'd3;
  localparam logic [2:0] PH_HOST   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [3:0] PAT_LEN   = 4'd12;
  localparam logic [2:0] SKIP_LEN  = 3'd5;
  localparam logic [7:0] QUOTE_CH  = 8'h3e;  // '>'

  // Field selector codes
  localparam logic FIELD_USER = 1'b0;
  localparam logic FIELD_HOST = 1'b1;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] skip_cnt;
    logic [3:0] match_pos;
    logic       host_seen;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field;
    logic       line_done;
    logic       has_host;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase: PH_FIRST, skip_cnt: 3'd0, match_pos: 4'd0, host_seen: 1'b0
  };

  // C-locale whitespace: space, tab, newline, vertical tab, form feed, return
  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  // Byte of "remote from " at a position
  function automatic logic [7:0] pat_byte(logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h72;  // r
      4'd1:    b = 8'h65;  // e
      4'd2:    b = 8'h6d;  // m
      4'd3:    b = 8'h6f;  // o
      4'd4:    b = 8'h74;  // t
      4'd5:    b = 8'h65;  // e
      4'd6:    b = 8'h20;  // space
      4'd7:    b = 8'h66;  // f
      4'd8:    b = 8'h72;  // r
      4'd9:    b = 8'h6f;  // o
      4'd10:   b = 8'h6d;  // m
      4'd11:   b = 8'h20;  // space
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Longest proper border of the pattern prefix ending at idx
  function automatic logic [3:0] border_of(logic [3:0] idx);
    return (idx == 4'd8) ? 4'd1 : 4'd0;
  endfunction

  // Advance the matcher by one byte; borders are shallow, so three fallbacks
  // cover every mismatch chain.
  function automatic logic [3:0] match_next(logic [3:0] pos_in, logic [7:0] c);
    logic [3:0] pos;
    pos = (pos_in >= PAT_LEN) ? 4'd0 : pos_in;
    for (int i = 0; i < 3; i++) begin
      if ((pos != 4'd0) && (pat_byte(pos) != c)) begin
        pos = border_of(pos - 4'd1);
      end
    end
    if (pat_byte(pos) == c) begin
      pos = pos + 4'd1;
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

/* hdl/mfle_if.sv */
// Valid/ready channel interfaces for line bytes in and field results out.
`default_nettype none

interface mfle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, ch, line_end, input ready);
  modport sink   (input valid, ch, line_end, output ready);
endinterface

interface mfle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       field;
  logic       line_done;
  logic       has_host;

  modport source (output valid, out_byte, byte_valid, field, line_done, has_host,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, field, line_done, has_host,
                  output ready);
endinterface

`default_nettype wire

/* hdl/mbox_from_line_field_extract.sv */
// Top level of the mail From-line field extractor.
// A byte accepted into the input register is parsed by mfle_step into the result
// register, which takes it only when free; out_o.ready low stalls both registers.
// Throughput: one byte per cycle when not stalled, set by the single parse step
// between the input and the result register; the result register frees the input.
// Reset: asynchronous, active low; clears both valid flags and the parse state.
`default_nettype none
`include "assert_macros.svh"

module mbox_from_line_field_extract (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfle_in_if.sink    in_i,
  mfle_out_if.source out_o
);

  logic              in_valid_q;
  logic [7:0]        ch_q;
  logic              line_end_q;
  logic              out_valid_q;
  logic              out_valid_d;
  mfle_pkg::result_t res_q;
  mfle_pkg::result_t res_d;
  mfle_pkg::state_t  state_q;
  mfle_pkg::state_t  state_d;
  logic              advance;
  logic              step;
  logic              in_take;

  // Handshake: move a byte into the parser when the result register frees up
  assign advance  = !out_valid_q || out_o.ready;
  assign step     = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;
  assign in_take  = in_i.valid && in_i.ready;

  mfle_step u_step (
    .state_i    (state_q),
    .ch_i       (ch_q),
    .line_end_i (line_end_q),
    .state_o    (state_d),
    .result_o   (res_d)
  );

  assign out_valid_d = step ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= mfle_pkg::STATE_RESET;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      if (step) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: hold the input byte and the result
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q       <= in_i.ch;
      line_end_q <= in_i.line_end;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = res_q.out_byte;
  assign out_o.byte_valid = res_q.byte_valid;
  assign out_o.field      = res_q.field;
  assign out_o.line_done  = res_q.line_done;
  assign out_o.has_host   = res_q.has_host;

  // Checks
  `MFLE_NEVER(a_host_flag_only_at_end,
    out_valid_q && !res_q.line_done && res_q.has_host,
    "has_host set on a result that does not close a line")
  `MFLE_NEVER(a_idle_byte_clear,
    out_valid_q && !res_q.byte_valid && ((res_q.out_byte != 8'h00) || res_q.field),
    "out_byte or field set without a field byte")
  `MFLE_ASSERT(a_line_end_resets,
    step && line_end_q |=> (state_q == mfle_pkg::STATE_RESET),
    "parse state not back at start after the last byte of a line")
  `MFLE_ASSERT(a_host_byte_seen,
    step && res_d.byte_valid && res_d.field && !line_end_q |=> state_q.host_seen,
    "host byte emitted without a recorded match")
  `MFLE_NEVER(a_match_pos_range,
    state_q.match_pos >= mfle_pkg::PAT_LEN,
    "matcher position past the pattern")

endmodule

`default_nettype wire

/* hdl/mfle_step.sv */
// One-byte step of the From-line parser: next state and result for a byte.
`default_nettype none

module mfle_step (
  input  mfle_pkg::state_t  state_i,
  input  logic [7:0]        ch_i,
  input  logic              line_end_i,
  output mfle_pkg::state_t  state_o,
  output mfle_pkg::result_t result_o
);

  mfle_pkg::state_t nxt;
  mfle_pkg::result_t res;
  logic [2:0] skip_dec;
  logic [3:0] pos_nxt;

  // Advance the parse phase for one byte
  always_comb begin
    nxt      = state_i;
    res      = '0;
    skip_dec = (state_i.skip_cnt != 3'd0) ? (state_i.skip_cnt - 3'd1) : 3'd0;
    pos_nxt  = mfle_pkg::match_next(state_i.match_pos, ch_i);

    if ((ch_i == 8'h00) && (state_i.phase != mfle_pkg::PH_DONE)) begin
      // string terminator: ignore the rest of the line
      nxt.phase = mfle_pkg::PH_DONE;
    end else begin
      case (state_i.phase)
        mfle_pkg::PH_FIRST: begin
          nxt.skip_cnt = (ch_i == mfle_pkg::QUOTE_CH) ? mfle_pkg::SKIP_LEN
                                                      : (mfle_pkg::SKIP_LEN - 3'd1);
          nxt.phase    = mfle_pkg::PH_SKIP;
        end
        mfle_pkg::PH_SKIP: begin
          nxt.skip_cnt = skip_dec;
          if (skip_dec == 3'd0) begin
            nxt.phase = mfle_pkg::PH_USER;
          end
        end
        mfle_pkg::PH_USER: begin
          if (mfle_pkg::is_ws(ch_i)) begin
            // whitespace that ends the user field already feeds the search
            nxt.phase     = mfle_pkg::PH_SEARCH;
            nxt.match_pos = mfle_pkg::match_next(4'd0, ch_i);
          end else begin
            res.out_byte   = ch_i;
            res.byte_valid = 1'b1;
            res.field      = mfle_pkg::FIELD_USER;
          end
        end
        mfle_pkg::PH_SEARCH: begin
          nxt.match_pos = pos_nxt;
          if (pos_nxt >= mfle_pkg::PAT_LEN) begin
            nxt.host_seen = 1'b1;
            nxt.match_pos = 4'd0;
            nxt.phase     = mfle_pkg::PH_HOST;
          end
        end
        mfle_pkg::PH_HOST: begin
          if (mfle_pkg::is_ws(ch_i)) begin
            nxt.phase = mfle_pkg::PH_DONE;
          end else begin
            res.out_byte   = ch_i;
            res.byte_valid = 1'b1;
            res.field      = mfle_pkg::FIELD_HOST;
          end
        end
        default: begin
          // done and unused codes: drop the byte
        end
      endcase
    end

    // Close the line and return to the start state
    if (line_end_i) begin
      res.line_done = 1'b1;
      res.has_host  = nxt.host_seen;
      nxt           = mfle_pkg::STATE_RESET;
    end
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

`default_nettype wire
